FILE: rtl/core/k_of_n_combination_generator_defines.svh
// Assertion macros used by the bound SVA checker in rtl/core/kcg_checker.sv.
`ifndef K_OF_N_COMBINATION_GENERATOR_DEFINES_SVH
`define K_OF_N_COMBINATION_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KCG_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kcg same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define KCG_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kcg next-cycle check failed");

`endif

FILE: rtl/core/kcg_pkg.sv
package kcg_pkg;

   localparam int MAX_ITEMS = 16;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int CSR_W     = 5;
   localparam int REQ_W     = 8;
   localparam int RSP_W     = 8;
   localparam int RSP_U_W   = 2;

   localparam logic [CSR_W-1:0] SET_SIZE_RST = CSR_W'(16);
   localparam logic [CSR_W-1:0] CHOOSE_RST   = CSR_W'(1);

   typedef enum logic {
      REG_SET_SIZE = 1'b0,
      REG_CHOOSE   = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_EMIT,
      S_EXHAUST
   } state_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic load_exh;
      logic load_idx;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic last;
      logic slot_free;
   } status_type;

   typedef struct packed {
      logic                 found;
      logic [MAX_ITEMS-1:0] next;
   } step_type;

   function automatic logic [CNT_W-1:0] eff_n(input logic [CSR_W-1:0] raw);
      logic [CNT_W-1:0] n;
      if (raw == '0) begin
         n = CNT_W'(1);
      end else if (raw > CSR_W'(MAX_ITEMS)) begin
         n = CNT_W'(MAX_ITEMS);
      end else begin
         n = CNT_W'(raw);
      end
      return n;
   endfunction

   function automatic logic [CNT_W-1:0] eff_k(input logic [CSR_W-1:0] raw,
                                              input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] k;
      if (raw == '0) begin
         k = CNT_W'(1);
      end else if (CNT_W'(raw) > n) begin
         k = n;
      end else begin
         k = CNT_W'(raw);
      end
      return k;
   endfunction

   function automatic logic [MAX_ITEMS-1:0] first_mask(input logic [CNT_W-1:0] k);
      logic [MAX_ITEMS:0] w;
      w = ((MAX_ITEMS + 1)'(1) << k) - (MAX_ITEMS + 1)'(1);
      return w[MAX_ITEMS-1:0];
   endfunction

   function automatic step_type step_prev(input logic [MAX_ITEMS-1:0] mask,
                                          input logic [CNT_W-1:0]     n);
      step_type         r;
      logic [CNT_W-1:0] p;
      logic [CNT_W-1:0] ones;
      r.found = 1'b0;
      r.next  = mask;
      p       = '0;
      ones    = '0;
      for (int i = 0; i < MAX_ITEMS - 1; i++) begin
         if (CNT_W'(i + 1) < n && mask[i] && !mask[i+1]) begin
            r.found = 1'b1;
            p       = CNT_W'(i);
         end
      end
      for (int i = 0; i < MAX_ITEMS; i++) begin
         if (CNT_W'(i) > p && CNT_W'(i) < n && mask[i]) begin
            ones = ones + CNT_W'(1);
         end
      end
      for (int i = 0; i < MAX_ITEMS; i++) begin
         if (CNT_W'(i) >= p && CNT_W'(i) < n) begin
            r.next[i] = 1'b0;
         end
         if (CNT_W'(i) > p && (CNT_W'(i) - p - CNT_W'(1)) <= ones) begin
            r.next[i] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] lowest_index(input logic [MAX_ITEMS-1:0] work);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
         if (work[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

FILE: rtl/core/k_of_n_combination_generator.sv
// Walks every K-of-N subset of 0..N-1 in lexicographic order. Each request
// word returns the chosen indices of the current subset, ascending, one word
// per index, tlast on the final index; tuser[0] marks the last subset and
// tuser[1] an exhausted reply once the walk has ended (until restart or a
// register write, both of which reload the first subset). A request is
// accepted in S_IDLE, S_CHECK steps the mask (or sees the walk is done),
// then one index per cycle, unless rsp_tready stalls, goes out through the
// single output register. A new request is taken once the last index (or
// the exhausted reply) of the previous one is in the output register.
module k_of_n_combination_generator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [kcg_pkg::CSR_W-1:0]       csr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kcg_pkg::REQ_W-1:0]       req_tdata,  // [0] restart
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kcg_pkg::RSP_W-1:0]       rsp_tdata,  // [3:0] chosen_index
   output logic                            rsp_tlast,
   output logic [kcg_pkg::RSP_U_W-1:0]     rsp_tuser   // [0] final_subset, [1] exhausted
);

   kcg_pkg::cmd_type    cmd;
   kcg_pkg::status_type status;

   kcg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kcg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_restart (req_tdata[0]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

FILE: rtl/core/kcg_ctrl.sv
module kcg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  kcg_pkg::status_type status,
   output kcg_pkg::cmd_type    cmd
);

   kcg_pkg::state_type state_ff;
   kcg_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kcg_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kcg_pkg::S_IDLE: begin
            if (req_tvalid) state_in = kcg_pkg::S_CHECK;
         end
         kcg_pkg::S_CHECK: begin
            state_in = status.done ? kcg_pkg::S_EXHAUST : kcg_pkg::S_EMIT;
         end
         kcg_pkg::S_EMIT: begin
            if (status.slot_free && status.last) state_in = kcg_pkg::S_IDLE;
         end
         kcg_pkg::S_EXHAUST: begin
            if (status.slot_free) state_in = kcg_pkg::S_IDLE;
         end
         default: state_in = kcg_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         kcg_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         kcg_pkg::S_CHECK: begin
            cmd.step = !status.done;
         end
         kcg_pkg::S_EMIT: begin
            cmd.load_idx = status.slot_free;
         end
         kcg_pkg::S_EXHAUST: begin
            cmd.load_exh = status.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/core/kcg_datapath.sv
module kcg_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [kcg_pkg::CSR_W-1:0]     csr_data,
   input  logic                          req_restart,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [kcg_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast,
   output logic [kcg_pkg::RSP_U_W-1:0]   rsp_tuser,
   input  kcg_pkg::cmd_type              cmd,
   output kcg_pkg::status_type           status
);

   logic [kcg_pkg::CSR_W-1:0]     set_size_ff, set_size_in;
   logic [kcg_pkg::CSR_W-1:0]     choose_ff, choose_in;
   logic [kcg_pkg::MAX_ITEMS-1:0] mask_ff, mask_in;
   logic                          done_ff, done_in;
   logic [kcg_pkg::MAX_ITEMS-1:0] work_ff, work_in;
   logic                          final_ff, final_in;
   logic                          out_valid_ff, out_valid_in;
   logic [kcg_pkg::IDX_W-1:0]     out_index_ff, out_index_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_final_ff, out_final_in;
   logic                          out_exh_ff, out_exh_in;

   logic [kcg_pkg::CNT_W-1:0]     n_now;
   logic [kcg_pkg::CNT_W-1:0]     n_new;
   logic [kcg_pkg::MAX_ITEMS-1:0] first_new;
   kcg_pkg::step_type             step;
   logic                          csr_write;
   logic                          work_last;
   logic                          slot_free;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign slot_free = !out_valid_ff || rsp_tready;
   assign work_last = (work_ff & (work_ff - kcg_pkg::MAX_ITEMS'(1))) == '0;

   assign n_now     = kcg_pkg::eff_n(set_size_ff);
   assign n_new     = kcg_pkg::eff_n(set_size_in);
   assign first_new = kcg_pkg::first_mask(kcg_pkg::eff_k(choose_in, n_new));
   assign step      = kcg_pkg::step_prev(mask_ff, n_now);

   always_comb begin
      set_size_in = set_size_ff;
      choose_in   = choose_ff;
      if (csr_write) begin
         unique case (kcg_pkg::reg_index_type'(csr_index))
            kcg_pkg::REG_SET_SIZE: set_size_in = csr_data;
            kcg_pkg::REG_CHOOSE:   choose_in   = csr_data;
            default:               set_size_in = set_size_ff;
         endcase
      end
   end

   always_comb begin
      mask_in  = mask_ff;
      done_in  = done_ff;
      work_in  = work_ff;
      final_in = final_ff;
      if (csr_write || (cmd.accept && req_restart)) begin
         mask_in = first_new;
         done_in = 1'b0;
      end else if (cmd.step) begin
         work_in  = mask_ff;
         final_in = !step.found;
         done_in  = !step.found;
         if (step.found) mask_in = step.next;
      end else if (cmd.load_idx) begin
         work_in = work_ff & (work_ff - kcg_pkg::MAX_ITEMS'(1));
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      out_final_in = out_final_ff;
      out_exh_in   = out_exh_ff;
      if (cmd.load_idx) begin
         out_valid_in = 1'b1;
         out_index_in = kcg_pkg::lowest_index(work_ff);
         out_last_in  = work_last;
         out_final_in = final_ff;
         out_exh_in   = 1'b0;
      end else if (cmd.load_exh) begin
         out_valid_in = 1'b1;
         out_index_in = '0;
         out_last_in  = 1'b0;
         out_final_in = 1'b0;
         out_exh_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff  <= kcg_pkg::SET_SIZE_RST;
         choose_ff    <= kcg_pkg::CHOOSE_RST;
         mask_ff      <= kcg_pkg::first_mask(kcg_pkg::CNT_W'(kcg_pkg::CHOOSE_RST));
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         set_size_ff  <= set_size_in;
         choose_ff    <= choose_in;
         mask_ff      <= mask_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      final_ff     <= final_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
      out_final_ff <= out_final_in;
      out_exh_ff   <= out_exh_in;
   end

   assign status.done      = done_ff;
   assign status.last      = work_last;
   assign status.slot_free = slot_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = kcg_pkg::RSP_W'(out_index_ff);
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_exh_ff, out_final_ff};

endmodule

FILE: rtl/core/kcg_checker.sv
`include "k_of_n_combination_generator_defines.svh"

module kcg_sva_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [kcg_pkg::RSP_W-1:0]     rsp_tdata,
   input logic                          rsp_tlast,
   input logic [kcg_pkg::RSP_U_W-1:0]   rsp_tuser
);

   `KCG_ASSERT_IMP(a_exh_clean, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tdata == '0 && !rsp_tlast && !rsp_tuser[0])
   `KCG_ASSERT_NXT(a_one_request, clock, reset, req_tvalid && req_tready, !req_tready)
   `KCG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

endmodule

bind k_of_n_combination_generator kcg_sva_checker u_kcg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

FILE: verif/kcg_checker.sv
module kcg_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [kcg_pkg::CSR_W-1:0]     csr_data,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [kcg_pkg::REQ_W-1:0]     req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [kcg_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          rsp_tlast,
   input  logic [kcg_pkg::RSP_U_W-1:0]   rsp_tuser,
   output int                            fail_count,
   output int                            pending,
   output int                            words_checked,
   output int                            final_words,
   output int                            exhausted_words
);

   typedef struct {
      logic [kcg_pkg::IDX_W-1:0] pos;
      logic                      last;
      logic                      fin;
      logic                      exh;
   } pick_word_type;

   pick_word_type                 expected_picks[$];
   logic [kcg_pkg::CSR_W-1:0]     n_raw;
   logic [kcg_pkg::CSR_W-1:0]     k_raw;
   logic [kcg_pkg::MAX_ITEMS-1:0] chosen_mask;
   logic                          walk_done;

   function automatic int active_n();
      if (n_raw == '0) return 1;
      if (n_raw > kcg_pkg::MAX_ITEMS) return kcg_pkg::MAX_ITEMS;
      return int'(n_raw);
   endfunction

   function automatic int active_k();
      int n;
      n = active_n();
      if (k_raw == '0) return 1;
      if (int'(k_raw) > n) return n;
      return int'(k_raw);
   endfunction

   function automatic void rewind_walk();
      chosen_mask = '0;
      for (int i = 0; i < active_k(); i++) chosen_mask[i] = 1'b1;
      walk_done = 1'b0;
   endfunction

   // Move to the next subset in lexicographic order; return 0 when the ones already sit at the end.
   function automatic bit retreat_mask();
      int n;
      int pivot;
      int tail;
      n = active_n();
      pivot = -1;
      tail = 0;
      for (int i = 0; i + 1 < n; i++) begin
         if (chosen_mask[i] && !chosen_mask[i+1]) pivot = i;
      end
      if (pivot < 0) return 1'b0;
      for (int i = pivot + 1; i < n; i++) begin
         if (chosen_mask[i]) tail++;
      end
      for (int i = pivot; i < n; i++) begin
         chosen_mask[i] = (i > pivot) && (i - pivot - 1 <= tail);
      end
      return 1'b1;
   endfunction

   function automatic void predict_picks(input logic restart);
      int                            n;
      int                            top;
      logic [kcg_pkg::MAX_ITEMS-1:0] snap;
      logic                          fin;
      if (restart) rewind_walk();
      if (walk_done) begin
         expected_picks.push_back('{'0, 1'b0, 1'b0, 1'b1});
         return;
      end
      n = active_n();
      snap = chosen_mask;
      top = 0;
      for (int i = 0; i < n; i++) begin
         if (snap[i]) top = i;
      end
      fin = !retreat_mask();
      if (fin) walk_done = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (snap[i]) begin
            expected_picks.push_back('{kcg_pkg::IDX_W'(i), logic'(i == top), fin, 1'b0});
         end
      end
   endfunction

   function automatic void note_mismatch(input string field, input int want, input int got);
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
   endfunction

   always @(posedge clock) begin
      pick_word_type want;
      if (reset) begin
         n_raw = kcg_pkg::SET_SIZE_RST;
         k_raw = kcg_pkg::CHOOSE_RST;
         rewind_walk();
         expected_picks.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            if (rsp_tuser[0]) final_words++;
            if (rsp_tuser[1]) exhausted_words++;
            if (expected_picks.size() == 0) begin
               $error("unexpected word: chosen_index %0d", rsp_tdata[kcg_pkg::IDX_W-1:0]);
               fail_count++;
            end else begin
               want = expected_picks.pop_front();
               if (rsp_tdata[kcg_pkg::IDX_W-1:0] !== want.pos)
                  note_mismatch("chosen_index", int'(want.pos),
                                int'(rsp_tdata[kcg_pkg::IDX_W-1:0]));
               if (rsp_tlast !== want.last)
                  note_mismatch("last_of_subset", int'(want.last), int'(rsp_tlast));
               if (rsp_tuser[0] !== want.fin)
                  note_mismatch("final_subset", int'(want.fin), int'(rsp_tuser[0]));
               if (rsp_tuser[1] !== want.exh)
                  note_mismatch("exhausted", int'(want.exh), int'(rsp_tuser[1]));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == kcg_pkg::REG_SET_SIZE) n_raw = csr_data;
            else k_raw = csr_data;
            rewind_walk();
         end
         if (req_tvalid && req_tready) predict_picks(req_tdata[0]);
      end
      pending = expected_picks.size();
   end

endmodule

FILE: verif/tb.sv
module tb;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic                          csr_index  = 1'b0;
   logic [kcg_pkg::CSR_W-1:0]     csr_data   = '0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [kcg_pkg::REQ_W-1:0]     req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [kcg_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          rsp_tlast;
   logic [kcg_pkg::RSP_U_W-1:0]   rsp_tuser;

   int fail_count;
   int pending;
   int words_checked;
   int final_words;
   int exhausted_words;

   int requests_sent = 0;
   int restarts_sent = 0;
   int reg_writes    = 0;
   int rsp_hold      = 0;
   bit busy_mode     = 1'b0;

   always #5 clock = ~clock;

   k_of_n_combination_generator uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   kcg_checker watch (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .pending         (pending),
      .words_checked   (words_checked),
      .final_words     (final_words),
      .exhausted_words (exhausted_words)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (busy_mode || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic write_reg(input kcg_pkg::reg_index_type which,
                            input logic [kcg_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      reg_writes++;
   endtask

   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (24) @(negedge clock);
   endtask

   task automatic configure(input logic [kcg_pkg::CSR_W-1:0] n,
                            input logic [kcg_pkg::CSR_W-1:0] k);
      settle();
      write_reg(kcg_pkg::REG_SET_SIZE, n);
      write_reg(kcg_pkg::REG_CHOOSE, k);
   endtask

   task automatic run_requests(input int count, input int restart_pct);
      int   gap;
      logic restart;
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         gap = pick_gap();
         restart = ($urandom_range(0, 99) < restart_pct);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {{(kcg_pkg::REQ_W-1){1'b0}}, restart};
         do @(posedge clock); while (!req_tready);
         requests_sent++;
         if (restart) restarts_sent++;
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
   endtask

   // Receiver: random stalls, plus a long hold whenever rsp_hold is loaded.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else begin
            if (stall == 0 && $urandom_range(0, 99) < 30) stall = pick_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               stall--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin
      #12_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int                        random_items;
      int                        phase;
      int                        cnt;
      int                        r;
      int                        n_eff;
      logic [kcg_pkg::CSR_W-1:0] n_val;
      logic [kcg_pkg::CSR_W-1:0] k_val;
      random_items = 0;
      phase = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      settle();
      run_requests(3, 0);
      run_requests(1, 100);
      configure(5'd4, 5'd2);
      run_requests(8, 0);
      run_requests(1, 100);
      configure(5'd31, 5'd16);
      run_requests(2, 0);
      run_requests(1, 100);
      configure(5'd0, 5'd0);
      run_requests(2, 0);
      settle();
      write_reg(kcg_pkg::REG_CHOOSE, 5'd20);
      write_reg(kcg_pkg::REG_SET_SIZE, 5'd5);
      run_requests(1, 0);
      configure(5'd2, 5'd1);
      run_requests(3, 0);

      while (random_items < 200) begin
         phase++;
         settle();
         busy_mode = (phase % 5 == 3);
         r = $urandom_range(0, 99);
         if (phase == 2) n_val = 5'd16;
         else if (r < 70) n_val = kcg_pkg::CSR_W'($urandom_range(1, 6));
         else if (r < 85) n_val = kcg_pkg::CSR_W'($urandom_range(7, 16));
         else if (r < 92) n_val = 5'd0;
         else n_val = kcg_pkg::CSR_W'($urandom_range(17, 31));
         n_eff = (n_val == 0) ? 1 :
                 (n_val > kcg_pkg::MAX_ITEMS) ? kcg_pkg::MAX_ITEMS : int'(n_val);
         r = $urandom_range(0, 99);
         if (phase == 2) k_val = kcg_pkg::CSR_W'($urandom_range(10, 16));
         else if (r < 80) k_val = kcg_pkg::CSR_W'($urandom_range(1, n_eff));
         else if (r < 90) k_val = 5'd0;
         else k_val = kcg_pkg::CSR_W'($urandom_range(0, 31));
         r = $urandom_range(0, 99);
         if (r < 15) begin
            write_reg(kcg_pkg::REG_CHOOSE, k_val);
         end else if (r < 30) begin
            write_reg(kcg_pkg::REG_SET_SIZE, n_val);
         end else if (r < 60) begin
            write_reg(kcg_pkg::REG_CHOOSE, k_val);
            write_reg(kcg_pkg::REG_SET_SIZE, n_val);
         end else begin
            write_reg(kcg_pkg::REG_SET_SIZE, n_val);
            write_reg(kcg_pkg::REG_CHOOSE, k_val);
         end
         if (phase == 2) rsp_hold = 400;
         cnt = $urandom_range(8, 30);
         run_requests(cnt, 6);
         random_items += cnt;
      end
      busy_mode = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("covered %0d requests (%0d restarts) over %0d register writes and %0d phases",
               requests_sent, restarts_sent, reg_writes, phase);
      $display("checked %0d index words: %0d in final subsets, %0d exhausted replies",
               words_checked, final_words, exhausted_words);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/kcg_pkg.sv
rtl/core/kcg_ctrl.sv
rtl/core/kcg_datapath.sv
rtl/core/k_of_n_combination_generator.sv
rtl/core/kcg_checker.sv
verif/kcg_checker.sv
verif/tb.sv
